// ===== hw/rtl/rbzs_pkg.sv =====
package rbzs_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;
  localparam int AmountW  = 9;
  localparam int FrW      = 20;

  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KIND   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_AMOUNT = 2'd3;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic KIND_ZOOM = 1'b0;
  localparam logic KIND_SPIN = 1'b1;

  localparam logic [35:0] AngleQ32 = 36'd74547170;
  localparam logic [31:0] HalfQ16  = 32'd32768;

  typedef struct packed {
    logic wr;
    logic start;
    logic div_step;
    logic set0;
    logic set1;
    logic mul_a;
    logic upd_x;
    logic mul_b;
    logic upd_y;
    logic rd_en;
    logic rd_path;
    logic emit;
  } cmd_t;

endpackage

// ===== hw/rtl/rbzs_ram.sv =====
module rbzs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rbzs_dpath.sv =====
module rbzs_dpath #(
  parameter int PatternSide = 128,
  parameter int PathSteps   = 64,
  parameter int DivW        = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rbzs_pkg::cmd_t                      cmd_i,
  input  logic [rbzs_pkg::CfgDataW-1:0]       cfg_width_i,
  input  logic [rbzs_pkg::CfgDataW-1:0]       cfg_height_i,
  input  logic                                cfg_kind_i,
  input  logic [rbzs_pkg::AmountW-1:0]        cfg_amount_i,
  input  logic [13:0]                         pattern_index_i,
  input  logic [7:0]                          pattern_value_i,
  input  logic [11:0]                         pixel_x_i,
  input  logic [11:0]                         pixel_y_i,
  output logic [7:0]                          grey_o
);
  import rbzs_pkg::*;

  localparam int Depth   = PatternSide * PatternSide;
  localparam int SideW   = $clog2(PatternSide);
  localparam int AddrW   = $clog2(Depth);
  localparam int RemW    = CfgDataW + 1;
  localparam int RecipSh = FrW + 8;
  localparam int RecipW  = RecipSh + 1;
  localparam int ProdW   = FrW + RecipW;
  localparam logic [SideW-1:0]  SideMax   = SideW'(PatternSide - 1);
  localparam logic [AddrW-1:0]  SideA     = AddrW'(PatternSide);
  localparam logic [RecipW-1:0] StepRecip =
    RecipW'(((64'd1 << RecipSh) + 64'(PathSteps - 1)) / 64'(PathSteps));

  logic [DivW-1:0]     dvd_q [2];
  logic [RemW-1:0]     rem_q [2];
  logic [CfgDataW-1:0] dvs   [2];
  logic [DivW-1:0]     dvd_d [2];
  logic [RemW-1:0]     rem_d [2];

  logic [CfgDataW-1:0] w_eff, h_eff;
  logic [35:0]         fr_full;
  logic [FrW-1:0]      fr_q;
  logic [ProdW-1:0]    s_prod;
  logic [11:0]         px_q, py_q;
  logic signed [31:0]  cx, cy, cxr, cyr, fx, fy;
  logic signed [31:0]  s_q, q_q, ns, len, sq;
  logic signed [31:0]  x1_q, y1_q, x2_q, y2_q;
  logic signed [31:0]  m1_q, m2_q, m3_q, m4_q, m5_q, m6_q, m7_q, m8_q;
  logic [SideW-1:0]    sx, sy;
  logic [AddrW-1:0]    start_addr, addr1, addr2, rd_addr;
  logic [7:0]          rdata;
  logic                rd_pend_q, ok_q, we;
  logic [7:0]          grey_q;

  function automatic logic [SideW-1:0] clamp_coord(logic signed [31:0] pos,
                                                   logic signed [31:0] ctr);
    logic signed [31:0] t;
    logic [SideW-1:0]   r;
    t = (pos + ctr) >>> 16;
    if (t < 0) begin
      r = '0;
    end else if (t > 32'(PatternSide - 1)) begin
      r = SideMax;
    end else begin
      r = t[SideW-1:0];
    end
    return r;
  endfunction

  function automatic logic [SideW-1:0] sat_quo(logic [DivW-1:0] v);
    logic [SideW-1:0] r;
    if (v > DivW'(PatternSide - 1)) begin
      r = SideMax;
    end else begin
      r = v[SideW-1:0];
    end
    return r;
  endfunction

  assign w_eff   = (cfg_width_i == '0) ? CfgDataW'(1) : cfg_width_i;
  assign h_eff   = (cfg_height_i == '0) ? CfgDataW'(1) : cfg_height_i;
  assign fr_full = 36'(cfg_amount_i) * AngleQ32;
  assign s_prod  = ProdW'(fr_q) * ProdW'(StepRecip);
  assign dvs[0]  = w_eff;
  assign dvs[1]  = h_eff;

  always_comb begin
    logic [RemW-1:0] rt;
    logic            ge;
    for (int l = 0; l < 2; l++) begin
      rt       = {rem_q[l][RemW-2:0], dvd_q[l][DivW-1]};
      ge       = rt >= {1'b0, dvs[l]};
      rem_d[l] = ge ? rt - {1'b0, dvs[l]} : rt;
      dvd_d[l] = {dvd_q[l][DivW-2:0], ge};
    end
  end

  assign cx  = 32'({w_eff, 15'b0});
  assign cy  = 32'({h_eff, 15'b0});
  assign cxr = cx + HalfQ16;
  assign cyr = cy + HalfQ16;
  assign fx  = {4'b0, px_q, 16'b0} - cx;
  assign fy  = {4'b0, py_q, 16'b0} - cy;
  assign ns  = -s_q;
  assign len = 32'(cfg_amount_i);
  assign sq  = s_q * s_q;

  assign sx         = sat_quo(dvd_q[0]);
  assign sy         = sat_quo(dvd_q[1]);
  assign start_addr = AddrW'(sy) * SideA + AddrW'(sx);
  assign addr1      = AddrW'(clamp_coord(y1_q, cyr)) * SideA + AddrW'(clamp_coord(x1_q, cxr));
  assign addr2      = AddrW'(clamp_coord(y2_q, cyr)) * SideA + AddrW'(clamp_coord(x2_q, cxr));
  assign rd_addr    = cmd_i.set0 ? start_addr : (cmd_i.rd_path ? addr2 : addr1);
  assign we         = cmd_i.wr && ({18'b0, pattern_index_i} < 32'(Depth));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
      fr_q <= fr_full[35:16];
      dvd_q[0] <= DivW'(pixel_x_i) * DivW'(PatternSide);
      dvd_q[1] <= DivW'(pixel_y_i) * DivW'(PatternSide);
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= '0;
      end
    end else if (cmd_i.div_step) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_d[l];
        dvd_q[l] <= dvd_d[l];
      end
    end
    if (cmd_i.set0) begin
      s_q  <= 32'(s_prod[ProdW-1:RecipSh]);
      x1_q <= fx;
      x2_q <= fx;
      y1_q <= fy;
      y2_q <= fy;
    end
    if (cmd_i.set1) begin
      q_q <= sq >>> 11;
    end
    if (cmd_i.mul_a) begin
      if (cfg_kind_i == KIND_SPIN) begin
        m1_q <= (y1_q >>> 8) * s_q;
        m2_q <= (x1_q >>> 14) * q_q;
        m5_q <= (y1_q >>> 14) * q_q;
        m3_q <= (y2_q >>> 8) * ns;
        m4_q <= (x2_q >>> 14) * q_q;
        m6_q <= (y2_q >>> 14) * q_q;
      end else begin
        m1_q <= (x1_q >>> 4) * len;
        m3_q <= (y1_q >>> 4) * len;
      end
    end
    if (cmd_i.upd_x) begin
      if (cfg_kind_i == KIND_SPIN) begin
        x1_q <= x1_q - (m1_q >>> 8) - (m2_q >>> 8);
        x2_q <= x2_q - (m3_q >>> 8) - (m4_q >>> 8);
      end else begin
        x1_q <= x1_q - (m1_q >>> 10);
        y1_q <= y1_q - (m3_q >>> 10);
      end
    end
    if (cmd_i.mul_b) begin
      m7_q <= (x1_q >>> 8) * s_q;
      m8_q <= (x2_q >>> 8) * ns;
    end
    if (cmd_i.upd_y) begin
      y1_q <= y1_q + (m7_q >>> 8) - (m5_q >>> 8);
      y2_q <= y2_q + (m8_q >>> 8) - (m6_q >>> 8);
    end
    if (cmd_i.emit) begin
      grey_q <= ok_q ? 8'hFF : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      ok_q      <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_en;
      if (cmd_i.start) begin
        ok_q <= 1'b1;
      end else if (rd_pend_q) begin
        ok_q <= ok_q && (rdata == 8'hFF);
      end
    end
  end

  rbzs_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(AddrW'(pattern_index_i)),
    .wdata_i(pattern_value_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  assign grey_o = grey_q;

endmodule

// ===== hw/rtl/rbzs_ctrl.sv =====
module rbzs_ctrl #(
  parameter int PathSteps = 64,
  parameter int DivW      = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_mode_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  logic           cfg_kind_i,
  output rbzs_pkg::cmd_t cmd_o
);
  import rbzs_pkg::*;

  localparam int CntMax = (DivW > PathSteps) ? DivW : PathSteps;
  localparam int CntW   = $clog2(CntMax + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SET0 = 3'd2;
  localparam logic [2:0] ST_SET1 = 3'd3;
  localparam logic [2:0] ST_STEP = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      ph_q, ph_d, last_ph;
  logic            out_valid_q, out_valid_d;
  logic            spin, acc;

  assign spin       = cfg_kind_i == KIND_SPIN;
  assign last_ph    = spin ? 2'd3 : 2'd1;
  assign in_ready_o = state_q == ST_IDLE;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    ph_d    = ph_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_mode_i == MODE_LOAD) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivW - 1)) begin
          state_d = ST_SET0;
        end
      end
      ST_SET0: begin
        cmd_o.set0  = 1'b1;
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SET1;
      end
      ST_SET1: begin
        cmd_o.set1 = 1'b1;
        cnt_d      = '0;
        ph_d       = '0;
        state_d    = ST_STEP;
      end
      ST_STEP: begin
        if (cnt_q == CntW'(PathSteps)) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_path = ph_q[0];
          if (!spin || ph_q[0]) begin
            state_d = ST_WAIT;
          end else begin
            ph_d = 2'd1;
          end
        end else begin
          case (ph_q)
            2'd0: begin
              cmd_o.mul_a = 1'b1;
              cmd_o.rd_en = cnt_q != '0;
            end
            2'd1: begin
              cmd_o.upd_x   = 1'b1;
              cmd_o.rd_en   = spin && (cnt_q != '0);
              cmd_o.rd_path = 1'b1;
            end
            2'd2: cmd_o.mul_b = 1'b1;
            2'd3: cmd_o.upd_y = 1'b1;
            default: ;
          endcase
          if (ph_q == last_ph) begin
            ph_d  = '0;
            cnt_d = cnt_q + CntW'(1);
          end else begin
            ph_d = ph_q + 2'd1;
          end
        end
      end
      ST_WAIT: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_mode_i == MODE_PIXEL) |=> state_q == ST_DIV)
    else $error("pixel beat did not start divide");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites pending beat");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP |-> cnt_q <= CntW'(PathSteps))
    else $error("step count past path length");
  a_wait_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT |-> $past(cmd_o.rd_en))
    else $error("wait without final read");

endmodule

// ===== hw/rtl/radial_blur_zoom_spin_pixel_top.sv =====
// Channel  | Signals                         | Beat contents
// in       | s_axis_tvalid/tready/tdata/tuser| tuser mode; tdata index, value, x, y
// out      | m_axis_tvalid/tready/tdata      | tdata grey_out
// config   | cfg_we_i/cfg_idx_i/cfg_data_i   | width, height, kind, amount
// A load beat is written to the pattern RAM when it is taken. A pixel beat runs a
// one-bit-per-cycle divider, then a path loop whose phases per step are multiply and
// update (zoom) or multiply, x update, multiply, y update (spin), set by the single
// read port of the pattern RAM and the multiply chain per step.
// Reset clears control and config registers; the pattern RAM is not cleared.
// A result waits in the output register; the next input beat is taken meanwhile.
module radial_blur_zoom_spin_pixel_top #(
  parameter int PatternSide = 128,
  parameter int PathSteps   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,  // index, value, pixel_x, pixel_y
  input  logic                              s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // grey_out
  input  logic                              cfg_we_i,
  input  logic [rbzs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rbzs_pkg::CfgDataW-1:0]     cfg_data_i
);
  import rbzs_pkg::*;

  localparam int NumW = 12 + $clog2(PatternSide) + 1;
  localparam int DivW = (NumW > FrW) ? NumW : FrW;

  logic [CfgDataW-1:0] width_q, height_q;
  logic                kind_q;
  logic [AmountW-1:0]  amount_q;
  cmd_t                cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgDataW'(10);
      height_q <= CfgDataW'(10);
      kind_q   <= KIND_ZOOM;
      amount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_KIND:   kind_q   <= cfg_data_i[0];
        CFG_AMOUNT: amount_q <= cfg_data_i[AmountW-1:0];
        default: ;
      endcase
    end
  end

  rbzs_ctrl #(
    .PathSteps(PathSteps),
    .DivW     (DivW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .cfg_kind_i (kind_q),
    .cmd_o      (cmd)
  );

  rbzs_dpath #(
    .PatternSide(PatternSide),
    .PathSteps  (PathSteps),
    .DivW       (DivW)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_width_i    (width_q),
    .cfg_height_i   (height_q),
    .cfg_kind_i     (kind_q),
    .cfg_amount_i   (amount_q),
    .pattern_index_i(s_axis_tdata[13:0]),
    .pattern_value_i(s_axis_tdata[21:14]),
    .pixel_x_i      (s_axis_tdata[33:22]),
    .pixel_y_i      (s_axis_tdata[45:34]),
    .grey_o         (m_axis_tdata)
  );

endmodule

// ===== tb/radial_blur_zoom_spin_pixel_top_tb.sv =====
module radial_blur_zoom_spin_pixel_top_tb;
  import rbzs_pkg::*;

  localparam int Side       = 128;
  localparam int Steps      = 64;
  localparam int StoreDepth = Side * Side;
  localparam int DrainWait  = 400;
  localparam int CycleLimit = 4000000;
  localparam int NumPhases  = 8;
  localparam int PhaseItems = 115;

  typedef struct {
    logic        mode;
    logic [13:0] idx;
    logic [7:0]  val;
    logic [11:0] px;
    logic [11:0] py;
    int          want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic [7:0]  grey_store [StoreDepth];
  logic [12:0] img_w, img_h;
  logic        kind_q;
  logic [8:0]  amount_q;
  logic [7:0]  grey_exp_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  dir_row_t    dir_rows[13];

  always #5 clk_i = ~clk_i;

  radial_blur_zoom_spin_pixel_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  function automatic logic [7:0] store_at(int xq, int xc, int yq, int yc);
    int u, v;
    u = (xq + xc) >>> 16;
    v = (yq + yc) >>> 16;
    if (u < 0) u = 0;
    if (u > Side - 1) u = Side - 1;
    if (v < 0) v = 0;
    if (v > Side - 1) v = Side - 1;
    return grey_store[v * Side + u];
  endfunction

  function automatic void spin_step(inout int x, inout int y, input int s, input int q);
    x = x - (((x >>> 0) - x) + (((y >>> 8) * s) >>> 8)) - (((x >>> 14) * q) >>> 8);
    y = y + (((x >>> 8) * s) >>> 8) - (((y >>> 14) * q) >>> 8);
  endfunction

  function automatic logic [7:0] blur_grey(int unsigned px, int unsigned py);
    int unsigned w, h, sx, sy, total, div;
    int cx, cy, cxr, cyr, fx, fy, s, q, x1, y1, x2, y2, len;
    longint fr;
    w = (img_w != 0) ? img_w : 1;
    h = (img_h != 0) ? img_h : 1;
    sx = px * Side / w;
    sy = py * Side / h;
    if (sx > Side - 1) sx = Side - 1;
    if (sy > Side - 1) sy = Side - 1;
    cx = w * 32768;
    cy = h * 32768;
    cxr = cx + 32768;
    cyr = cy + 32768;
    fx = (px << 16) - cx;
    fy = (py << 16) - cy;
    total = grey_store[sy * Side + sx];
    if (kind_q == KIND_SPIN) begin
      fr = (longint'(amount_q) * 64'd74547170) >> 16;
      s = int'(fr) / Steps;
      q = (s * s) >>> 11;
      x1 = fx; y1 = fy; x2 = fx; y2 = fy;
      for (int i = 0; i < Steps; i++) begin
        spin_step(x1, y1, s, q);
        spin_step(x2, y2, -s, q);
        total += store_at(x1, cxr, y1, cyr);
        total += store_at(x2, cxr, y2, cyr);
      end
      div = 2 * Steps + 1;
    end else begin
      len = amount_q;
      for (int i = 0; i < Steps; i++) begin
        fx = fx - (((fx >>> 4) * len) >>> 10);
        fy = fy - (((fy >>> 4) * len) >>> 10);
        total += store_at(fx, cxr, fy, cyr);
      end
      div = Steps + 1;
    end
    total = total / div;
    return (total >= 255) ? 8'd255 : 8'd0;
  endfunction

  task automatic send_beat(logic mode, logic [13:0] idx, logic [7:0] val,
                           logic [11:0] px, logic [11:0] py, int want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {2'b00, py, px, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == MODE_LOAD) begin
      grey_store[idx] = val;
    end else if (want >= 0) begin
      grey_exp_q.push_back(want[7:0]);
    end else begin
      grey_exp_q.push_back(blur_grey(px, py));
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_WIDTH:  img_w = data;
      CFG_HEIGHT: img_h = data;
      CFG_KIND:   kind_q = data[0];
      default:    amount_q = data[8:0];
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (grey_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic random_beat();
    int unsigned xr, yr;
    logic [7:0] v;
    if ($urandom_range(99) < 40) begin
      v = ($urandom_range(99) < 80) ? 8'd255 : 8'($urandom);
      send_beat(MODE_LOAD, 14'($urandom), v, '0, '0, -1);
    end else begin
      xr = (img_w > 4096 || img_w == 0) ? 4095 : img_w - 1;
      yr = (img_h > 4096 || img_h == 0) ? 4095 : img_h - 1;
      if ($urandom_range(99) < 15) begin
        xr = 4095;
        yr = 4095;
      end
      send_beat(MODE_PIXEL, '0, 8'($urandom), 12'($urandom_range(xr)),
                12'($urandom_range(yr)), -1);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grey_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: grey_out=%0d", m_axis_tdata);
      end else begin
        if (m_axis_tdata !== grey_exp_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("grey_out mismatch: expected %0d actual %0d", grey_exp_q[0], m_axis_tdata);
        end
        void'(grey_exp_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int ph_w[NumPhases], ph_h[NumPhases], ph_k[NumPhases], ph_a[NumPhases];
    img_w = 13'd10;
    img_h = 13'd10;
    kind_q = KIND_ZOOM;
    amount_q = '0;
    ph_w = '{1, 4096, 128, 64, 4096, 10, 0, 0};
    ph_h = '{1, 4096, 128, 32, 1, 10, 0, 0};
    ph_k = '{0, 1, 1, 0, 0, 1, 0, 1};
    ph_a = '{360, 360, 1, 200, 17, 0, 0, 0};
    dir_rows = '{
      '{MODE_PIXEL, 14'd0,     8'd0,    12'd0,     12'd0,     255},
      '{MODE_PIXEL, 14'd0,     8'd0,    12'd4095,  12'd4095,  255},
      '{MODE_PIXEL, 14'd0,     8'd0,    12'd9,     12'd9,     255},
      '{MODE_LOAD,  14'd0,     8'd0,    12'd0,     12'd0,     -1},
      '{MODE_PIXEL, 14'd0,     8'd0,    12'd0,     12'd0,     0},
      '{MODE_LOAD,  14'd16383, 8'd0,    12'd0,     12'd0,     -1},
      '{MODE_PIXEL, 14'd0,     8'd0,    12'd4095,  12'd4095,  -1},
      '{MODE_LOAD,  14'd16256, 8'hAA,   12'd0,     12'd0,     -1},
      '{MODE_LOAD,  14'd127,   8'h55,   12'd0,     12'd0,     -1},
      '{MODE_PIXEL, 14'd0,     8'd0,    12'd5,     12'd5,     -1},
      '{MODE_PIXEL, 14'd0,     8'd0,    12'hAAA,   12'h555,   -1},
      '{MODE_LOAD,  14'h2AAA,  8'd255,  12'd0,     12'd0,     -1},
      '{MODE_LOAD,  14'h1555,  8'd255,  12'd0,     12'd0,     -1}
    };
    for (int i = 6; i < NumPhases; i++) begin
      ph_w[i] = $urandom_range(1, 300);
      ph_h[i] = $urandom_range(1, 300);
      ph_a[i] = $urandom_range(0, 360);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole store so no path ever reads an unwritten entry
    for (int i = 0; i < StoreDepth; i++) send_beat(MODE_LOAD, 14'(i), 8'd255, '0, '0, -1);
    for (int i = 0; i < $size(dir_rows); i++)
      send_beat(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].val,
                dir_rows[i].px, dir_rows[i].py, dir_rows[i].want);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      write_reg(CFG_WIDTH, CfgDataW'(ph_w[p]));
      write_reg(CFG_HEIGHT, CfgDataW'(ph_h[p]));
      write_reg(CFG_KIND, CfgDataW'(ph_k[p]));
      write_reg(CFG_AMOUNT, CfgDataW'(ph_a[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        random_beat();
        if (p == 2 && i == PhaseItems / 2) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (grey_exp_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (mismatches == 0 && grey_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
